### rtl/core/bpm_pkg.sv
// Shared types, codes and constants of the battery power manager.
package bpm_pkg;

	localparam int SMOOTH_DEPTH_DEF = 10;

	// item kinds
	localparam logic [1:0] MODE_SAMPLE  = 2'd0;
	localparam logic [1:0] MODE_CONTROL = 2'd1;
	localparam logic [1:0] MODE_SLOW    = 2'd2;

	// power states as seen on power_state
	localparam logic [1:0] PS_OFF  = 2'd0;
	localparam logic [1:0] PS_CHG  = 2'd1;
	localparam logic [1:0] PS_ON   = 2'd2;
	localparam logic [1:0] PS_SHUT = 2'd3;

	// display commands
	localparam logic [1:0] DC_NONE     = 2'd0;
	localparam logic [1:0] DC_SHUTDOWN = 2'd1;
	localparam logic [1:0] DC_CHARGING = 2'd2;
	localparam logic [1:0] DC_NORMAL   = 2'd3;

	// register indexes
	localparam logic CFG_INACTION_LIMIT = 1'b0;
	localparam logic CFG_CHARGE_MAX     = 1'b1;

	localparam logic [11:0] CHARGE_MAX_RST = 12'd1000;

	typedef struct packed {
		logic capture;
		logic conv1;
		logic conv2;
		logic ring_wr;
		logic sum_step;
		logic div1;
		logic div2;
		logic update;
		logic load_out;
	} bpm_cmd_t;

	typedef struct packed {
		logic is_sample;
		logic sum_last;
	} bpm_stat_t;

	// floor(x*100/22) for x = 0..22
	function automatic logic [6:0] level_pct(input logic [4:0] x);
		logic [6:0] r;
		case (x)
			5'd0:  r = 7'd0;
			5'd1:  r = 7'd4;
			5'd2:  r = 7'd9;
			5'd3:  r = 7'd13;
			5'd4:  r = 7'd18;
			5'd5:  r = 7'd22;
			5'd6:  r = 7'd27;
			5'd7:  r = 7'd31;
			5'd8:  r = 7'd36;
			5'd9:  r = 7'd40;
			5'd10: r = 7'd45;
			5'd11: r = 7'd50;
			5'd12: r = 7'd54;
			5'd13: r = 7'd59;
			5'd14: r = 7'd63;
			5'd15: r = 7'd68;
			5'd16: r = 7'd72;
			5'd17: r = 7'd77;
			5'd18: r = 7'd81;
			5'd19: r = 7'd86;
			5'd20: r = 7'd90;
			5'd21: r = 7'd95;
			default: r = 7'd100;
		endcase
		return r;
	endfunction

endpackage

### rtl/core/bpm_ctrl.sv
// Sequencer of the battery power manager: walks one item through the datapath.
module bpm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  bpm_pkg::bpm_stat_t stat,
	output bpm_pkg::bpm_cmd_t  cmd
);
	import bpm_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_CONV1 = 9'b000000010,
		S_CONV2 = 9'b000000100,
		S_WRITE = 9'b000001000,
		S_SUM   = 9'b000010000,
		S_DIV1  = 9'b000100000,
		S_DIV2  = 9'b001000000,
		S_UPD   = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = stat.is_sample ? S_CONV1 : S_UPD;
				end
			end
			S_CONV1: begin
				cmd.conv1 = 1'b1;
				state_d = S_CONV2;
			end
			S_CONV2: begin
				cmd.conv2 = 1'b1;
				state_d = S_WRITE;
			end
			S_WRITE: begin
				cmd.ring_wr = 1'b1;
				state_d = S_SUM;
			end
			S_SUM: begin
				cmd.sum_step = 1'b1;
				if (stat.sum_last)
					state_d = S_DIV1;
			end
			S_DIV1: begin
				cmd.div1 = 1'b1;
				state_d = S_DIV2;
			end
			S_DIV2: begin
				cmd.div2 = 1'b1;
				state_d = S_UPD;
			end
			S_UPD: begin
				cmd.update = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

### rtl/core/bpm_dp.sv
// Datapath of the battery power manager: conversions, rings, averages, state updates.
module bpm_dp #(
	parameter int SMOOTH_DEPTH = bpm_pkg::SMOOTH_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bpm_pkg::bpm_cmd_t  cmd,
	output bpm_pkg::bpm_stat_t stat,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic [1:0]         mode,
	input  logic [9:0]         volt_adc,
	input  logic [9:0]         curr_adc,
	input  logic               motor_permit,
	input  logic               switch_level,
	input  logic signed [15:0] motor_speed,
	input  logic [15:0]        inaction_time,
	input  logic               display_done,
	output logic [1:0]         power_state,
	output logic               enable_out,
	output logic               led_on,
	output logic [1:0]         display_cmd,
	output logic               clear_inaction,
	output logic [7:0]         battery_volt,
	output logic signed [12:0] battery_ma,
	output logic signed [8:0]  calc_volt,
	output logic signed [7:0]  charge_level,
	output logic               charging,
	output logic               supply_ok,
	output logic [7:0]         charge_pwm
);
	import bpm_pkg::*;

	localparam int IW  = $clog2(SMOOTH_DEPTH);
	localparam int VSW = 8 + IW;
	localparam int CSW = 13 + IW;
	localparam int SH  = CSW;
	localparam logic [SH:0]    RECIP = (SH+1)'((1 << SH) / SMOOTH_DEPTH);
	localparam logic [CSW-1:0] NC    = CSW'(SMOOTH_DEPTH);
	localparam logic [IW-1:0]  LAST  = IW'(SMOOTH_DEPTH - 1);

	// captured item
	logic [1:0]         mode_q;
	logic [9:0]         vadc_q, cadc_q;
	logic               permit_q, sw_q, done_q;
	logic signed [15:0] speed_q;
	logic [15:0]        inact_q;

	// config
	logic [15:0] lim_q;
	logic [11:0] ccm_q;

	// architectural state
	logic [7:0]         volt_ring [SMOOTH_DEPTH];
	logic signed [12:0] curr_ring [SMOOTH_DEPTH];
	logic [IW-1:0]      slot_q, idx_q;
	logic signed [8:0]  rest_q;
	logic               sag_q, charge_q, supply_q, swp_q, led_q, en_q;
	logic signed [7:0]  level_q;
	logic [1:0]         ps_q;
	logic [7:0]         pwm_q;
	logic [1:0]         dcmd_q;
	logic               clr_q;
	logic [7:0]         vavg_q;
	logic signed [12:0] cavg_q;

	// conversion / averaging pipeline
	logic [10:0]        vp_s1;
	logic [20:0]        cp_s1;
	logic               cneg_s1;
	logic [7:0]         vent_s2;
	logic signed [12:0] cent_s2;
	logic [VSW-1:0]     vsum_q;
	logic signed [CSW-1:0] csum_q;
	logic [CSW-1:0]     vqe_q, cqe_q;

	assign stat.is_sample = (mode == MODE_SAMPLE);
	assign stat.sum_last  = (idx_q == LAST);

	// conversion stage 1
	logic [20:0]        vprod;
	logic signed [10:0] cdiff;
	logic [9:0]         cdmag;
	assign vprod = 21'(vadc_q) * 21'd1133;
	assign cdiff = $signed({1'b0, cadc_q}) - 11'sd510;
	assign cdmag = cdiff[10] ? 10'(-cdiff) : cdiff[9:0];

	// conversion stage 2: /5 and /625 by reciprocal
	logic [21:0] vq5;
	logic [41:0] cq625;
	logic [12:0] cmag13;
	assign vq5    = 22'(vp_s1) * 22'd3277;
	assign cq625  = 42'(cp_s1) * 42'd1717987;
	assign cmag13 = {1'b0, cq625[41:30]};

	// ring average divide
	logic [CSW-1:0]    vmag, cmag;
	logic [CSW+SH:0]   vprd, cprd;
	logic [CSW-1:0]    vrem, crem, vq, cq;
	assign vmag = CSW'(vsum_q);
	assign cmag = csum_q[CSW-1] ? CSW'(-csum_q) : CSW'(csum_q);
	assign vprd = (CSW+SH+1)'(vmag) * (CSW+SH+1)'(RECIP);
	assign cprd = (CSW+SH+1)'(cmag) * (CSW+SH+1)'(RECIP);
	assign vrem = vmag - vqe_q * NC;
	assign crem = cmag - cqe_q * NC;
	assign vq   = (vrem >= NC) ? vqe_q + CSW'(1) : vqe_q;
	assign cq   = (crem >= NC) ? cqe_q + CSW'(1) : cqe_q;

	// sample update
	logic signed [9:0] v10, rv_n, lim_v;
	logic              armed_n, charge_n;
	logic signed [7:0] level_n;
	logic [4:0]        lidx;
	always_comb begin
		v10     = $signed({2'b00, vavg_q});
		rv_n    = 10'(rest_q);
		armed_n = sag_q | permit_q;
		if (v10 - rv_n > 10'sd20) begin
			armed_n = 1'b0;
			rv_n    = v10 - 10'sd8;
		end
		if (charge_q) begin
			armed_n = 1'b0;
			rv_n    = v10 - 10'sd8;
		end else begin
			lim_v = armed_n ? v10 : v10 - 10'sd8;
			if (lim_v < rv_n)
				rv_n = lim_v;
		end
		lim_v = v10;
		charge_n = charge_q;
		if (supply_q && cavg_q > 13'sd200)
			charge_n = 1'b1;
		if (!supply_q || cavg_q < 13'sd100)
			charge_n = 1'b0;
		if (rv_n < 10'sd127)
			lidx = 5'd0;
		else if (rv_n > 10'sd149)
			lidx = 5'd22;
		else
			lidx = 5'(rv_n - 10'sd127);
		if (vavg_q < 8'd5)
			level_n = -8'sd1;
		else
			level_n = $signed({1'b0, level_pct(lidx)});
	end

	// control update: power-switch machine
	logic       edge_c, fast;
	logic [15:0] inact_c;
	logic [1:0] ps_n, dcmd_n;
	logic       clr_n, en_n, led_c;
	always_comb begin
		edge_c  = sw_q & ~swp_q;
		fast    = (speed_q > 16'sd30) || (speed_q < -16'sd30);
		inact_c = inact_q;
		ps_n    = ps_q;
		dcmd_n  = DC_NONE;
		clr_n   = 1'b0;
		en_n    = en_q;
		led_c   = led_q;
		if (ps_n == PS_ON && edge_c) begin
			ps_n = PS_SHUT; dcmd_n = DC_SHUTDOWN;
		end
		if (ps_n == PS_OFF && charge_q) begin
			ps_n = PS_CHG; dcmd_n = DC_CHARGING;
		end
		if (ps_n == PS_CHG && !charge_q) begin
			ps_n = PS_SHUT; dcmd_n = DC_SHUTDOWN;
		end
		if ((ps_n == PS_OFF || ps_n == PS_CHG) && (edge_c || fast)) begin
			ps_n = PS_ON; en_n = 1'b1; led_c = 1'b1;
			dcmd_n = DC_NORMAL; clr_n = 1'b1; inact_c = '0;
		end
		if (ps_n == PS_ON && lim_q != 16'd0 && inact_c > lim_q) begin
			ps_n = PS_SHUT; dcmd_n = DC_SHUTDOWN;
		end
		// completion only from a step that began in shutting-down
		if (ps_q == PS_SHUT && ps_n == PS_SHUT && done_q) begin
			ps_n = PS_OFF; led_c = 1'b0; en_n = 1'b0;
		end
	end

	// slow update
	logic              led_s, supply_n;
	logic [7:0]        pwm_n;
	logic signed [13:0] ma14, ccm14;
	always_comb begin
		ma14  = {cavg_q[12], cavg_q};
		ccm14 = $signed({2'b00, ccm_q});
		led_s = led_q;
		if (ps_q == PS_ON)
			led_s = 1'b1;
		else if (ps_q == PS_OFF)
			led_s = 1'b0;
		else if (ps_q == PS_CHG)
			led_s = ~led_q;
		supply_n = (cavg_q > -13'sd40);
		pwm_n = pwm_q;
		if (level_q < 8'sd0 || !supply_n)
			pwm_n = 8'd64;
		if (ma14 < ccm14 && pwm_n != 8'd255 && supply_n)
			pwm_n = pwm_n + 8'd1;
		if (ma14 > ccm14 + 14'sd300 && pwm_n != 8'd0 && supply_n)
			pwm_n = pwm_n - 8'd1;
	end

	// payload pipeline, no reset
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q   <= mode;
			vadc_q   <= volt_adc;
			cadc_q   <= curr_adc;
			permit_q <= motor_permit;
			sw_q     <= switch_level;
			speed_q  <= motor_speed;
			inact_q  <= inaction_time;
			done_q   <= display_done;
		end
		if (cmd.conv1) begin
			vp_s1   <= vprod[20:10];
			cp_s1   <= 21'(cdmag) * 21'd4069;
			cneg_s1 <= cdiff[10];
		end
		if (cmd.conv2) begin
			vent_s2 <= vq5[21:14];
			cent_s2 <= cneg_s1 ? -$signed(cmag13) : $signed(cmag13);
		end
		if (cmd.ring_wr) begin
			idx_q  <= '0;
			vsum_q <= '0;
			csum_q <= '0;
		end else if (cmd.sum_step) begin
			idx_q  <= idx_q + IW'(1);
			vsum_q <= vsum_q + VSW'(volt_ring[idx_q]);
			csum_q <= csum_q + CSW'(curr_ring[idx_q]);
		end
		if (cmd.div1) begin
			vqe_q <= vprd[CSW+SH-1:SH];
			cqe_q <= cprd[CSW+SH-1:SH];
		end
		if (cmd.load_out) begin
			power_state    <= ps_q;
			enable_out     <= en_q;
			led_on         <= led_q;
			display_cmd    <= dcmd_q;
			clear_inaction <= clr_q;
			battery_volt   <= vavg_q;
			battery_ma     <= cavg_q;
			calc_volt      <= rest_q;
			charge_level   <= level_q;
			charging       <= charge_q;
			supply_ok      <= supply_q;
			charge_pwm     <= pwm_q;
		end
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SMOOTH_DEPTH; i++) begin
				volt_ring[i] <= '0;
				curr_ring[i] <= '0;
			end
			slot_q   <= '0;
			rest_q   <= '0;
			sag_q    <= 1'b0;
			charge_q <= 1'b0;
			supply_q <= 1'b0;
			level_q  <= '0;
			ps_q     <= PS_ON;
			swp_q    <= 1'b0;
			led_q    <= 1'b0;
			pwm_q    <= '0;
			en_q     <= 1'b1;
			dcmd_q   <= DC_NONE;
			clr_q    <= 1'b0;
			vavg_q   <= '0;
			cavg_q   <= '0;
			lim_q    <= '0;
			ccm_q    <= CHARGE_MAX_RST;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_INACTION_LIMIT)
					lim_q <= cfg_data;
				else
					ccm_q <= cfg_data[11:0];
			end
			if (cmd.ring_wr) begin
				volt_ring[slot_q] <= vent_s2;
				curr_ring[slot_q] <= cent_s2;
				slot_q <= (slot_q == LAST) ? '0 : slot_q + IW'(1);
			end
			if (cmd.div2) begin
				vavg_q <= vq[7:0];
				cavg_q <= csum_q[CSW-1] ? -$signed(cq[12:0]) : $signed(cq[12:0]);
			end
			if (cmd.update) begin
				dcmd_q <= DC_NONE;
				clr_q  <= 1'b0;
				case (mode_q)
					MODE_SAMPLE: begin
						rest_q   <= rv_n[8:0];
						sag_q    <= armed_n;
						charge_q <= charge_n;
						level_q  <= level_n;
					end
					MODE_CONTROL: begin
						ps_q   <= ps_n;
						swp_q  <= sw_q;
						en_q   <= en_n;
						led_q  <= led_c;
						dcmd_q <= dcmd_n;
						clr_q  <= clr_n;
					end
					MODE_SLOW: begin
						led_q    <= led_s;
						supply_q <= supply_n;
						pwm_q    <= pwm_n;
					end
					default: ;
				endcase
			end
		end
	end

endmodule

### rtl/core/battery_power_manager.sv
// Top level of the battery power manager: sequencer plus datapath.
// One item is taken at a time and gives exactly one result. A sample item
// (mode 0) converts both readings, writes them into SMOOTH_DEPTH-entry rings,
// re-sums the rings one entry per cycle and divides by reciprocal with one
// correction step, then updates the state and loads the result. Control
// (mode 1), slow (mode 2) and mode 3 items skip the conversion, ring and
// divide steps and go straight to the update and output steps. A new item
// is taken only once the previous result has been loaded. A stalled result
// holds back the loading of the following one, and so the intake, until the
// stall is released. The output register holds a finished result while the
// next item is taken in.
// Configuration writes are always ready; write only while the block is idle.
module battery_power_manager #(
	parameter int SMOOTH_DEPTH = bpm_pkg::SMOOTH_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// item input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         mode,
	input  logic [9:0]         volt_adc,
	input  logic [9:0]         curr_adc,
	input  logic               motor_permit,
	input  logic               switch_level,
	input  logic signed [15:0] motor_speed,
	input  logic [15:0]        inaction_time,
	input  logic               display_done,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         power_state,
	output logic               enable_out,
	output logic               led_on,
	output logic [1:0]         display_cmd,
	output logic               clear_inaction,
	output logic [7:0]         battery_volt,
	output logic signed [12:0] battery_ma,
	output logic signed [8:0]  calc_volt,
	output logic signed [7:0]  charge_level,
	output logic               charging,
	output logic               supply_ok,
	output logic [7:0]         charge_pwm,
	// configuration write channel: 0 inaction_limit, 1 charge_current_max
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data
);
	import bpm_pkg::*;

	bpm_cmd_t  cmd;
	bpm_stat_t stat;

	// registers take a transfer in any cycle
	assign cfg_ready = 1'b1;

	bpm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	bpm_dp #(
		.SMOOTH_DEPTH (SMOOTH_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_we         (cfg_valid & cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mode           (mode),
		.volt_adc       (volt_adc),
		.curr_adc       (curr_adc),
		.motor_permit   (motor_permit),
		.switch_level   (switch_level),
		.motor_speed    (motor_speed),
		.inaction_time  (inaction_time),
		.display_done   (display_done),
		.power_state    (power_state),
		.enable_out     (enable_out),
		.led_on         (led_on),
		.display_cmd    (display_cmd),
		.clear_inaction (clear_inaction),
		.battery_volt   (battery_volt),
		.battery_ma     (battery_ma),
		.calc_volt      (calc_volt),
		.charge_level   (charge_level),
		.charging       (charging),
		.supply_ok      (supply_ok),
		.charge_pwm     (charge_pwm)
	);

endmodule
